>>> rtl/lpm_pkg.sv
// Package for the longest prefix route lookup block.
// Holds field widths, status codes, route and search token types, mask helper.
// No dependencies.
`default_nettype none

package lpm_pkg;

  localparam int unsigned AddrW        = 32;
  localparam int unsigned LenW         = 6;
  localparam int unsigned PortW        = 3;
  localparam int unsigned TtlW         = 8;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned MaxRoutesDef = 16;
  localparam logic [LenW-1:0] FullLen  = LenW'(AddrW);

  // command codes
  localparam logic CmdAdd   = 1'b0;
  localparam logic CmdRoute = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_FORWARD     = 3'd0,
    ST_NO_ROUTE    = 3'd1,
    ST_TTL_EXPIRED = 3'd2,
    ST_ADDED       = 3'd3,
    ST_FULL        = 3'd4
  } status_e;

  // one stored route; the mask is derived once at write time
  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic [LenW-1:0]  len;
    logic             hop_valid;
    logic [AddrW-1:0] hop_addr;
    logic [PortW-1:0] port;
  } lpm_route_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] dest;
    logic [TtlW-1:0]  ttl;
    logic             found;
    logic [LenW-1:0]  best_len;
    logic [PortW-1:0] best_port;
    logic [AddrW-1:0] best_hop;
  } lpm_tok_t;

  // mask of the high-order bits for a length of 0..32
  function automatic logic [AddrW-1:0] mask_of(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {AddrW{1'b1}} << (FullLen - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lpm_if.sv
// Channel interfaces of the route lookup block: request and response.
// Depends on nothing; widths match lpm_pkg.
`default_nettype none

interface lpm_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] pfx_addr;
  logic [5:0]  pfx_len;
  logic        has_next_hop;
  logic [31:0] next_hop_addr;
  logic [2:0]  port_in;
  logic [31:0] dest_addr;
  logic [7:0]  ttl_in;

  modport source (
    output valid, command, pfx_addr, pfx_len, has_next_hop,
           next_hop_addr, port_in, dest_addr, ttl_in,
    input  ready
  );
  modport sink (
    input  valid, command, pfx_addr, pfx_len, has_next_hop,
           next_hop_addr, port_in, dest_addr, ttl_in,
    output ready
  );
  modport mon (
    input valid, ready, command, pfx_addr, pfx_len, has_next_hop,
          next_hop_addr, port_in, dest_addr, ttl_in
  );
endinterface

interface lpm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  port_out;
  logic [31:0] hop_addr_out;
  logic [7:0]  ttl_out;

  modport source (
    output valid, status, port_out, hop_addr_out, ttl_out,
    input  ready
  );
  modport sink (
    input  valid, status, port_out, hop_addr_out, ttl_out,
    output ready
  );
  modport mon (
    input valid, ready, status, port_out, hop_addr_out, ttl_out
  );
endinterface

`default_nettype wire

>>> rtl/lpm_cell.sv
// One route cell of the lookup chain: holds a route, compares the passing token.
// Depends on lpm_pkg.
`default_nettype none

module lpm_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      occ_i,
  input  wire                      wr_en_i,
  input  wire lpm_pkg::lpm_route_t wr_route_i,
  input  wire lpm_pkg::lpm_tok_t   tok_i,
  output lpm_pkg::lpm_tok_t        tok_o
);
  import lpm_pkg::*;

  lpm_route_t route_q;
  lpm_tok_t   tok_d, tok_q;
  logic       hit;

  // store the route when this cell is the next free slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      route_q <= wr_route_i;
    end
  end

  // match on masked bits; strictly longer wins so the earliest route keeps ties
  always_comb begin
    hit   = occ_i && (((tok_i.dest ^ route_q.prefix) & route_q.mask) == '0)
            && (!tok_i.found || (route_q.len > tok_i.best_len));
    tok_d = tok_i;
    if (hit) begin
      tok_d.found     = 1'b1;
      tok_d.best_len  = route_q.len;
      tok_d.best_port = route_q.port;
      tok_d.best_hop  = route_q.hop_valid ? route_q.hop_addr : tok_i.dest;
    end
  end

  // advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

>>> rtl/longest_prefix_route_lookup.sv
// IPv4 longest prefix match route table built as a chain of route cells.
// Depends on lpm_pkg, lpm_if (lpm_req_if, lpm_rsp_if) and lpm_cell.
//
// Usage: requests arrive on req_i (valid/ready). Command add appends a route
// into the next free cell and answers route added, or table full once
// MAX_ROUTES routes are held. Command route launches a search token into
// cell 0; the token steps one cell per cycle, each cell keeping the longest
// match seen so far (earlier cell wins a tie). Every request yields exactly
// one transaction on rsp_o.
// An add's answer passes through the holding register and then the response
// register; a lookup's token first walks the chain of cell registers.
// One request is in work at a time: the next is taken once the previous
// result has moved into the response register.
// While the receiver stalls rsp_o the result waits in the response register
// and a new request is accepted meanwhile; that request's result then waits
// in a holding register, and no further request is taken until it moves on.
// Reset empties the table (route count zero) and drops any request in work.
`default_nettype none

module longest_prefix_route_lookup #(
  parameter int unsigned MAX_ROUTES = lpm_pkg::MaxRoutesDef
) (
  input wire        clk_i,
  input wire        rst_ni,
  lpm_req_if.sink   req_i,
  lpm_rsp_if.source rsp_o
);
  import lpm_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ROUTES + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            busy_q, busy_d;
  logic            res_valid_q, res_valid_d;
  logic            out_valid_q, out_valid_d;
  logic [StatusW-1:0] res_status_q, out_status_q;
  logic [PortW-1:0]   res_port_q, out_port_q;
  logic [AddrW-1:0]   res_hop_q, out_hop_q;
  logic [TtlW-1:0]    res_ttl_q, out_ttl_q;

  logic       accept, add_acc, add_ok, full, out_load;
  lpm_route_t wr_route;
  lpm_tok_t   launch_tok;
  lpm_tok_t   tok [MAX_ROUTES+1];
  status_e    fin_status;
  logic [StatusW-1:0] res_status_d;
  logic [PortW-1:0]   res_port_d;
  logic [AddrW-1:0]   res_hop_d;
  logic [TtlW-1:0]    res_ttl_d;

  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign add_acc     = accept && (req_i.command == CmdAdd);
  assign full        = (count_q == CntW'(MAX_ROUTES));
  assign add_ok      = add_acc && !full;
  assign out_load    = res_valid_q && (!out_valid_q || rsp_o.ready);

  // route to store, with the length saturated to 32
  always_comb begin
    wr_route.prefix    = req_i.pfx_addr;
    wr_route.len       = (req_i.pfx_len > FullLen) ? FullLen : req_i.pfx_len;
    wr_route.mask      = mask_of(wr_route.len);
    wr_route.hop_valid = req_i.has_next_hop;
    wr_route.hop_addr  = req_i.next_hop_addr;
    wr_route.port      = req_i.port_in;
  end

  // launch token for a lookup
  always_comb begin
    launch_tok.valid     = accept && (req_i.command == CmdRoute);
    launch_tok.dest      = req_i.dest_addr;
    launch_tok.ttl       = req_i.ttl_in;
    launch_tok.found     = 1'b0;
    launch_tok.best_len  = '0;
    launch_tok.best_port = '0;
    launch_tok.best_hop  = '0;
  end

  assign tok[0] = launch_tok;

  // chain of route cells
  for (genvar k = 0; k < MAX_ROUTES; k++) begin : g_cell
    lpm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .occ_i      (count_q > CntW'(k)),
      .wr_en_i    (add_ok && (count_q == CntW'(k))),
      .wr_route_i (wr_route),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1])
    );
  end

  // turn the token leaving the chain into a lookup verdict
  always_comb begin
    priority if (!tok[MAX_ROUTES].found) begin
      fin_status = ST_NO_ROUTE;
    end else if (tok[MAX_ROUTES].ttl <= TtlW'(1)) begin
      fin_status = ST_TTL_EXPIRED;
    end else begin
      fin_status = ST_FORWARD;
    end
  end

  // pick the result to hold: add answer or lookup verdict
  always_comb begin
    res_status_d = res_status_q;
    res_port_d   = res_port_q;
    res_hop_d    = res_hop_q;
    res_ttl_d    = res_ttl_q;
    if (add_acc) begin
      res_status_d = full ? ST_FULL : ST_ADDED;
      res_port_d   = '0;
      res_hop_d    = '0;
      res_ttl_d    = '0;
    end else if (tok[MAX_ROUTES].valid) begin
      res_status_d = fin_status;
      if (fin_status == ST_FORWARD) begin
        res_port_d = tok[MAX_ROUTES].best_port;
        res_hop_d  = tok[MAX_ROUTES].best_hop;
        res_ttl_d  = tok[MAX_ROUTES].ttl - TtlW'(1);
      end else begin
        res_port_d = '0;
        res_hop_d  = '0;
        res_ttl_d  = '0;
      end
    end
  end

  // control next state
  always_comb begin
    count_d     = add_ok ? count_q + CntW'(1) : count_q;
    busy_d      = busy_q;
    res_valid_d = res_valid_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (add_acc || tok[MAX_ROUTES].valid) begin
      res_valid_d = 1'b1;
    end
    if (out_load) begin
      res_valid_d = 1'b0;
      busy_d      = 1'b0;
    end
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result, then move it to the response register
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_port_q   <= res_port_d;
    res_hop_q    <= res_hop_d;
    res_ttl_q    <= res_ttl_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_port_q   <= res_port_q;
      out_hop_q    <= res_hop_q;
      out_ttl_q    <= res_ttl_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.port_out     = out_port_q;
  assign rsp_o.hop_addr_out = out_hop_q;
  assign rsp_o.ttl_out      = out_ttl_q;

endmodule

`default_nettype wire

>>> rtl/lpm_chk.sv
// Port-level checker for the route lookup block, bound to the top level.
// Depends on lpm_pkg and lpm_if.
`default_nettype none

module lpm_chk (
  input wire        clk_i,
  input wire        rst_ni,
  lpm_req_if.sink   req_i,
  lpm_rsp_if.source rsp_o
);
  import lpm_pkg::*;

  // a stalled response stays valid with status, hop address and TTL held
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> (rsp_o.valid && $stable(rsp_o.status)
      && $stable(rsp_o.hop_addr_out) && $stable(rsp_o.ttl_out)))
    else $error("response changed while stalled");

  // drop the detail fields unless forwarded
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_FORWARD)) |->
      (rsp_o.port_out == '0 && rsp_o.hop_addr_out == '0 && rsp_o.ttl_out == '0))
    else $error("detail fields set on a non-forward result");

  // a forwarded datagram keeps a live TTL
  a_fwd_ttl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_FORWARD)) |-> (rsp_o.ttl_out != '0))
    else $error("forwarded with zero TTL");

  // one request in work: ready drops after an accepted transaction
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while one is in work");

endmodule

bind longest_prefix_route_lookup lpm_chk u_lpm_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

`default_nettype wire

>>> sim/tb_longest_prefix_route_lookup.sv
`timescale 1ns / 100ps
// Self-checking testbench for longest_prefix_route_lookup: directed table, then random traffic.
// Depends on lpm_pkg, lpm_req_if / lpm_rsp_if and the block itself.

module tb_longest_prefix_route_lookup;
  import lpm_pkg::*;

  localparam int unsigned TableDepth = MaxRoutesDef;
  localparam int unsigned DrainCycles = TableDepth + 8;
  localparam int unsigned RandomItems = 450;

  typedef struct {
    logic             cmd;
    logic [AddrW-1:0] prefix;
    logic [LenW-1:0]  len;
    logic             hop_valid;
    logic [AddrW-1:0] hop;
    logic [PortW-1:0] port;
    logic [AddrW-1:0] dest;
    logic [TtlW-1:0]  ttl;
  } route_req_t;

  typedef struct {
    status_e          status;
    logic [PortW-1:0] port;
    logic [AddrW-1:0] hop;
    logic [TtlW-1:0]  ttl;
  } route_rsp_t;

  // directed row: request plus an optional hand-written answer
  typedef struct {
    route_req_t req;
    bit         pinned;
    route_rsp_t rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  lpm_req_if req_if ();
  lpm_rsp_if rsp_if ();

  longest_prefix_route_lookup #(
    .MAX_ROUTES(TableDepth)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow route table
  logic [AddrW-1:0] tbl_prefix    [TableDepth];
  logic [LenW-1:0]  tbl_len       [TableDepth];
  logic             tbl_hop_valid [TableDepth];
  logic [AddrW-1:0] tbl_hop       [TableDepth];
  logic [PortW-1:0] tbl_port      [TableDepth];
  int unsigned      tbl_count;

  route_rsp_t route_verdicts[$];
  int unsigned fail_count;

  // hand-written answer for the transaction now on the request channel
  bit         pin_valid;
  route_rsp_t pin_rsp;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  dir_row_t dir_rows[$];

  function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= LenW'(AddrW)) begin
      m = '1;
    end else begin
      m = {AddrW{1'b1}} << (AddrW - len);
    end
    return m;
  endfunction

  // apply one request to the shadow table and return its answer
  function automatic route_rsp_t predict_verdict(input route_req_t r);
    route_rsp_t  v;
    logic [LenW-1:0] l;
    bit          found;
    int unsigned best;
    logic [LenW-1:0] best_len;
    v.status = ST_FORWARD;
    v.port = '0;
    v.hop = '0;
    v.ttl = '0;
    found = 0;
    best = 0;
    best_len = '0;
    if (r.cmd == CmdAdd) begin
      if (tbl_count >= TableDepth) begin
        v.status = ST_FULL;
      end else begin
        l = (r.len > LenW'(AddrW)) ? LenW'(AddrW) : r.len;
        tbl_prefix[tbl_count] = r.prefix;
        tbl_len[tbl_count] = l;
        tbl_hop_valid[tbl_count] = r.hop_valid;
        tbl_hop[tbl_count] = r.hop;
        tbl_port[tbl_count] = r.port;
        tbl_count++;
        v.status = ST_ADDED;
      end
    end else begin
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if ((((r.dest ^ tbl_prefix[i]) & prefix_mask(tbl_len[i])) == '0) &&
            (!found || tbl_len[i] > best_len)) begin
          found = 1;
          best = i;
          best_len = tbl_len[i];
        end
      end
      if (!found) begin
        v.status = ST_NO_ROUTE;
      end else if (r.ttl <= 8'd1) begin
        v.status = ST_TTL_EXPIRED;
      end else begin
        v.status = ST_FORWARD;
        v.port = tbl_port[best];
        v.hop = tbl_hop_valid[best] ? tbl_hop[best] : r.dest;
        v.ttl = r.ttl - 8'd1;
      end
    end
    return v;
  endfunction

  function automatic route_rsp_t blank_rsp(input status_e st);
    route_rsp_t v;
    v.status = st;
    v.port = '0;
    v.hop = '0;
    v.ttl = '0;
    return v;
  endfunction

  function automatic dir_row_t mk_add(input logic [AddrW-1:0] prefix,
                                      input logic [LenW-1:0] len,
                                      input logic hop_valid,
                                      input logic [AddrW-1:0] hop,
                                      input logic [PortW-1:0] port);
    dir_row_t row;
    row.req.cmd = CmdAdd;
    row.req.prefix = prefix;
    row.req.len = len;
    row.req.hop_valid = hop_valid;
    row.req.hop = hop;
    row.req.port = port;
    row.req.dest = '0;
    row.req.ttl = '0;
    row.pinned = 1;
    row.rsp = blank_rsp(ST_ADDED);
    return row;
  endfunction

  function automatic dir_row_t mk_lookup(input logic [AddrW-1:0] dest,
                                         input logic [TtlW-1:0] ttl,
                                         input bit pinned,
                                         input status_e st);
    dir_row_t row;
    row.req.cmd = CmdRoute;
    row.req.prefix = '0;
    row.req.len = '0;
    row.req.hop_valid = 1'b0;
    row.req.hop = '0;
    row.req.port = '0;
    row.req.dest = dest;
    row.req.ttl = ttl;
    row.pinned = pinned;
    row.rsp = blank_rsp(st);
    return row;
  endfunction

  // append one row to the directed table
  function automatic void queue_row(input dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // random request, aimed mostly at routes already held
  function automatic route_req_t random_request();
    route_req_t r;
    int unsigned idx;
    logic [AddrW-1:0] keep;
    r.cmd = ($urandom_range(0, 99) < 20) ? CmdAdd : CmdRoute;
    r.prefix = $urandom;
    r.len = ($urandom_range(0, 99) < 30) ? LenW'($urandom_range(0, 63))
                                          : LenW'($urandom_range(8, 32));
    r.hop_valid = 1'($urandom_range(0, 1));
    r.hop = $urandom;
    r.port = PortW'($urandom_range(0, 7));
    r.dest = $urandom;
    r.ttl = ($urandom_range(0, 99) < 20) ? TtlW'($urandom_range(0, 2))
                                          : TtlW'($urandom_range(0, 255));
    if (tbl_count > 0 && $urandom_range(0, 99) < 60) begin
      idx = $urandom_range(0, tbl_count - 1);
      keep = prefix_mask(tbl_len[idx]);
      if (r.cmd == CmdAdd) begin
        // nest or tie with a held route
        r.prefix = (tbl_prefix[idx] & keep) | (r.prefix & ~keep);
      end else begin
        r.dest = (tbl_prefix[idx] & keep) | (r.dest & ~keep);
      end
    end
    return r;
  endfunction

  // present one transaction and hold it until accepted; call at a falling edge
  task automatic drive_request(input route_req_t r, input bit pinned,
                               input route_rsp_t prsp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.command = r.cmd;
    req_if.pfx_addr = r.prefix;
    req_if.pfx_len = r.len;
    req_if.has_next_hop = r.hop_valid;
    req_if.next_hop_addr = r.hop;
    req_if.port_in = r.port;
    req_if.dest_addr = r.dest;
    req_if.ttl_in = r.ttl;
    pin_valid = pinned;
    pin_rsp = prsp;
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver back-pressure, changed at the falling edge
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // check answers against the oldest expectation, then record new requests
  always @(posedge clk_i) begin
    route_rsp_t want;
    route_req_t got_req;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (route_verdicts.size() == 0) begin
          $error("response with nothing expected: status %0d", rsp_if.status);
          fail_count++;
        end else begin
          want = route_verdicts.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            fail_count++;
          end
          if (rsp_if.port_out !== want.port) begin
            $error("port_out: expected %0d, got %0d", want.port, rsp_if.port_out);
            fail_count++;
          end
          if (rsp_if.hop_addr_out !== want.hop) begin
            $error("hop_addr_out: expected %h, got %h", want.hop, rsp_if.hop_addr_out);
            fail_count++;
          end
          if (rsp_if.ttl_out !== want.ttl) begin
            $error("ttl_out: expected %0d, got %0d", want.ttl, rsp_if.ttl_out);
            fail_count++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        got_req.cmd = req_if.command;
        got_req.prefix = req_if.pfx_addr;
        got_req.len = req_if.pfx_len;
        got_req.hop_valid = req_if.has_next_hop;
        got_req.hop = req_if.next_hop_addr;
        got_req.port = req_if.port_in;
        got_req.dest = req_if.dest_addr;
        got_req.ttl = req_if.ttl_in;
        want = predict_verdict(got_req);
        if (pin_valid) begin
          want = pin_rsp;
        end
        route_verdicts = {route_verdicts, want};
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    route_req_t rr;
    route_rsp_t none;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CmdAdd;
    req_if.pfx_addr = '0;
    req_if.pfx_len = '0;
    req_if.has_next_hop = 1'b0;
    req_if.next_hop_addr = '0;
    req_if.port_in = '0;
    req_if.dest_addr = '0;
    req_if.ttl_in = '0;
    pin_valid = 0;
    pin_rsp = blank_rsp(ST_FORWARD);
    none = blank_rsp(ST_FORWARD);
    tbl_count = 0;
    fail_count = 0;
    send_idle_pct = 34;
    recv_idle_pct = 84;

    // lookups on an empty table, low TTL included
    queue_row(mk_lookup(32'h0A01_0203, 8'd64, 1, ST_NO_ROUTE));
    queue_row(mk_lookup(32'hFFFF_FFFF, 8'd0, 1, ST_NO_ROUTE));
    // nested routes, a tie on length, a host route at all ones
    queue_row(mk_add(32'h0A00_0000, 6'd8, 1'b0, 32'hFFFF_FFFF, 3'd1));
    queue_row(mk_add(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 3'd2));
    queue_row(mk_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0000_0000, 3'd3));
    queue_row(mk_add(32'hFFFF_FFFF, 6'd32, 1'b1, 32'hFFFF_FFFF, 3'd7));
    // length above 32 saturates to a host route
    queue_row(mk_add(32'h0000_0000, 6'd63, 1'b1, 32'h1234_5678, 3'd4));
    // stray prefix bits below the mask, next hop absent
    queue_row(mk_add(32'hC0A8_01FF, 6'd24, 1'b0, 32'hDEAD_BEEF, 3'd5));
    queue_row(mk_lookup(32'h0A01_0203, 8'd255, 0, ST_FORWARD));
    queue_row(mk_lookup(32'h0A02_0304, 8'd2, 0, ST_FORWARD));
    queue_row(mk_lookup(32'h0A02_0304, 8'd1, 1, ST_TTL_EXPIRED));
    queue_row(mk_lookup(32'h0A02_0304, 8'd0, 1, ST_TTL_EXPIRED));
    queue_row(mk_lookup(32'hFFFF_FFFF, 8'd255, 0, ST_FORWARD));
    queue_row(mk_lookup(32'h0000_0000, 8'd100, 0, ST_FORWARD));
    queue_row(mk_lookup(32'h0000_0001, 8'd100, 1, ST_NO_ROUTE));
    queue_row(mk_lookup(32'hC0A8_0177, 8'd9, 0, ST_FORWARD));
    // default route matches everything
    queue_row(mk_add(32'h1234_5678, 6'd0, 1'b1, 32'h0808_0808, 3'd6));
    queue_row(mk_lookup(32'h0000_0001, 8'd100, 0, ST_FORWARD));
    queue_row(mk_lookup(32'h0A01_FFFF, 8'd1, 1, ST_TTL_EXPIRED));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // walk the directed table
    foreach (dir_rows[i]) begin
      drive_request(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].rsp);
    end

    // random traffic in three idling phases
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 34;
      end else if (n == 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      rr = random_request();
      drive_request(rr, 0, none);
    end
    req_if.valid = 1'b0;
    pin_valid = 0;

    // drain outstanding answers, then watch for strays
    while (route_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lpm_pkg.sv
rtl/lpm_if.sv
rtl/lpm_cell.sv
rtl/longest_prefix_route_lookup.sv
rtl/lpm_chk.sv
sim/tb_longest_prefix_route_lookup.sv
